[rtl/core/arxps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package arxps_pkg;

  // default sizing of the model
  localparam int DEF_A_TAPS       = 3;
  localparam int DEF_B_TAPS       = 3;
  localparam int DEF_MAX_DELAY    = 16;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // q4.12 coefficient format
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // coefficient registers that exist per feedback and feedforward side
  localparam int COEF_REGS = 3;

  // configuration register map
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int DELAY_FIELD_WIDTH = 5;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COEF_A0     = 3'd0,
    REG_COEF_A1     = 3'd1,
    REG_COEF_A2     = 3'd2,
    REG_COEF_B0     = 3'd3,
    REG_COEF_B1     = 3'd4,
    REG_COEF_B2     = 3'd5,
    REG_DELAY_STEPS = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/core/arxps_sum.sv]
`timescale 1ns / 1ps
`default_nettype none

module arxps_sum
  import arxps_pkg::*;
#(
  parameter int A_TAPS       = DEF_A_TAPS,
  parameter int B_TAPS       = DEF_B_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic signed [COEF_WIDTH-1:0]   coef_a [A_TAPS],
  input  logic signed [COEF_WIDTH-1:0]   coef_b [B_TAPS],
  input  logic signed [SAMPLE_WIDTH-1:0] u_hist [B_TAPS],
  input  logic signed [SAMPLE_WIDTH-1:0] y_hist [A_TAPS],
  output logic signed [SAMPLE_WIDTH-1:0] y
);

  localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + $clog2(A_TAPS + B_TAPS) + 1;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam logic signed [ACC_WIDTH-1:0] SMAX =
    ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_WIDTH-1:0] SMIN = -SMAX - 1;

  logic signed [PROD_WIDTH-1:0] prod_a [A_TAPS];
  logic signed [PROD_WIDTH-1:0] prod_b [B_TAPS];
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  acc_rnd;
  logic signed [ACC_WIDTH-1:0]  acc_shr;

  // one multiplier per tap, all in parallel
  always_comb begin
    for (int k = 0; k < A_TAPS; k++) begin
      prod_a[k] = coef_a[k] * y_hist[k];
    end
    for (int k = 0; k < B_TAPS; k++) begin
      prod_b[k] = coef_b[k] * u_hist[k];
    end
  end

  // feedforward minus feedback, then round half up and saturate
  always_comb begin
    acc = '0;
    for (int k = 0; k < B_TAPS; k++) begin
      acc = acc + ACC_WIDTH'(prod_b[k]);
    end
    for (int k = 0; k < A_TAPS; k++) begin
      acc = acc - ACC_WIDTH'(prod_a[k]);
    end
    acc_rnd = acc + ACC_WIDTH'(ROUND_HALF);
    acc_shr = acc_rnd >>> FRAC_BITS;
    if (acc_shr > SMAX) begin
      y = SMAX[SAMPLE_WIDTH-1:0];
    end else if (acc_shr < SMIN) begin
      y = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = acc_shr[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/arx_plant_simulator.sv]
`timescale 1ns / 1ps
`default_nettype none

// ARX plant model with a transport delay, q4.12 fixed point. Every sample
// goes through a delay line of delay_steps samples (zero passes it straight
// through, values above MAX_DELAY act as MAX_DELAY), is pushed into the input
// history, and one output is produced per sample: sum of b[k] * u[k] minus
// sum of a[k] * y[k], rounded half up back to q4.12, saturated to
// SAMPLE_WIDTH bits and fed back into the output history. One item is taken
// every cycle unless out_ready holds the output back; the delay memory is
// read and the stage register loaded at the edge that accepts a sample, and
// the filter runs from the stage register into the output register once that
// register is free or being drained. The feedback loop sets the longest path:
// all multipliers, the adder tree, rounding and saturation sit between the
// output history registers combinationally. The delay line is a memory of
// 2**$clog2(MAX_DELAY+1) entries with a fill count, so there is no clearing
// pass after reset or after a delay write: entries older than the fill count
// read as zero. Configuration writes are always accepted (cfg_ready is tied
// high) and must only happen while the block is idle.

module arx_plant_simulator
  import arxps_pkg::*;
#(
  parameter int A_TAPS       = DEF_A_TAPS,
  parameter int B_TAPS       = DEF_B_TAPS,
  parameter int MAX_DELAY    = DEF_MAX_DELAY,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,

  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data,

  // input samples
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,

  // model outputs
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] plant_out
);

  // delay count and memory pointer share one width; depth exceeds MAX_DELAY
  // so the read slot differs from the slot being written for any nonzero delay
  localparam int DW    = $clog2(MAX_DELAY + 1);
  localparam int DEPTH = 1 << DW;

  // handshakes
  logic cfg_fire;
  logic in_fire;
  logic advance;

  // configuration registers
  logic signed [COEF_WIDTH-1:0] coef_a [A_TAPS];
  logic signed [COEF_WIDTH-1:0] coef_b [B_TAPS];
  logic [DW-1:0]                delay;
  logic [DW-1:0]                delay_next;

  // delay line memory and its bookkeeping
  logic signed [SAMPLE_WIDTH-1:0] dline [DEPTH];
  logic [DW-1:0]                  wp;
  logic [DW-1:0]                  fill_cnt;
  logic [DW-1:0]                  rd_addr;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;

  // stage register between accept and filter
  logic                           s_valid;
  logic signed [SAMPLE_WIDTH-1:0] s_sample;
  logic                           s_bypass;
  logic                           s_live;
  logic signed [SAMPLE_WIDTH-1:0] delayed;

  // histories, newest first
  logic signed [SAMPLE_WIDTH-1:0] u_hist [B_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] u_hist_next [B_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] y_hist [A_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] y_new;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  // the filter stage moves when the output register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s_valid || advance;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------

  // clamp the 5-bit delay field to MAX_DELAY
  always_comb begin
    if (int'(cfg_data[DELAY_FIELD_WIDTH-1:0]) > MAX_DELAY) begin
      delay_next = DW'(MAX_DELAY);
    end else begin
      delay_next = DW'(cfg_data[DELAY_FIELD_WIDTH-1:0]);
    end
  end

  // taps beyond the third have no register and stay at zero from reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < A_TAPS; k++) begin
        coef_a[k] <= '0;
      end
      for (int k = 0; k < B_TAPS; k++) begin
        coef_b[k] <= '0;
      end
      delay <= '0;
    end else if (cfg_fire) begin
      for (int k = 0; k < A_TAPS; k++) begin
        if (k < COEF_REGS &&
            cfg_index == CFG_INDEX_WIDTH'(int'(REG_COEF_A0) + k)) begin
          coef_a[k] <= cfg_data;
        end
      end
      for (int k = 0; k < B_TAPS; k++) begin
        if (k < COEF_REGS &&
            cfg_index == CFG_INDEX_WIDTH'(int'(REG_COEF_B0) + k)) begin
          coef_b[k] <= cfg_data;
        end
      end
      if (cfg_index == REG_DELAY_STEPS) begin
        delay <= delay_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // transport delay: circular buffer, fill count stands in for clearing
  // ---------------------------------------------------------------------

  // the sample written delay items ago sits delay slots behind the write slot
  assign rd_addr = wp - delay;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data   <= dline[rd_addr];
      dline[wp] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      fill_cnt <= '0;
    end else if (cfg_fire && cfg_index == REG_DELAY_STEPS) begin
      // a delay write empties the line
      fill_cnt <= '0;
    end else if (in_fire) begin
      wp <= wp + 1'b1;
      if (int'(fill_cnt) < MAX_DELAY) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage register
  // ---------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_sample <= sample_in;
      s_bypass <= (delay == '0);
      s_live   <= (fill_cnt >= delay);
    end
  end

  // zero delay passes the sample, a slot not yet refilled reads as zero
  always_comb begin
    if (s_bypass) begin
      delayed = s_sample;
    end else if (s_live) begin
      delayed = rd_data;
    end else begin
      delayed = '0;
    end
  end

  // ---------------------------------------------------------------------
  // filter and histories
  // ---------------------------------------------------------------------

  always_comb begin
    u_hist_next[0] = delayed;
    for (int k = 1; k < B_TAPS; k++) begin
      u_hist_next[k] = u_hist[k-1];
    end
  end

  arxps_sum #(
    .A_TAPS       (A_TAPS),
    .B_TAPS       (B_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_sum (
    .coef_a (coef_a),
    .coef_b (coef_b),
    .u_hist (u_hist_next),
    .y_hist (y_hist),
    .y      (y_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < B_TAPS; k++) begin
        u_hist[k] <= '0;
      end
      for (int k = 0; k < A_TAPS; k++) begin
        y_hist[k] <= '0;
      end
    end else if (s_valid && advance) begin
      for (int k = 0; k < B_TAPS; k++) begin
        u_hist[k] <= u_hist_next[k];
      end
      y_hist[0] <= y_new;
      for (int k = 1; k < A_TAPS; k++) begin
        y_hist[k] <= y_hist[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && advance) begin
      plant_out <= y_new;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // the result on the port is the newest entry of the feedback history
  a_out_matches_hist : assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> plant_out == y_hist[0]
  ) else $error("plant_out differs from newest output history");

  // fill count saturates at the maximum delay
  a_fill_bounded : assert property (
    @(posedge clk) disable iff (rst)
    int'(fill_cnt) <= MAX_DELAY
  ) else $error("delay line fill count above MAX_DELAY");

  // a delay write empties the delay line
  a_delay_write_clears : assert property (
    @(posedge clk) disable iff (rst)
    cfg_fire && cfg_index == REG_DELAY_STEPS |=> fill_cnt == '0
  ) else $error("delay write did not clear the delay line");

  // an accepted item occupies the stage in the next cycle
  a_accept_loads_stage : assert property (
    @(posedge clk) disable iff (rst)
    in_fire |=> s_valid
  ) else $error("accepted item lost before the filter stage");

endmodule

`default_nettype wire
